### rtl/mbd_pkg.sv
// package for the 2x2 box downsampler
// holds widths, register map, shared types and the channel arithmetic
// used by mbd_regs, mbd_line_store and mip_box_downsample_2x2_top
package mbd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int N_CHAN        = 4;
    localparam int CHAN_W        = 8;
    localparam int SUM_W         = CHAN_W + 1;
    localparam int PIX_W         = N_CHAN * CHAN_W;
    localparam int PAIR_W        = N_CHAN * SUM_W;
    localparam int SRC_W_W       = 13;
    localparam int SRC_H_W       = 16;
    localparam int APB_DW        = 32;
    localparam int APB_AW        = 3;

    // register indexes (byte address is 4 * index)
    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    typedef struct packed {
        logic [SRC_W_W-1:0] src_width;
        logic [SRC_H_W-1:0] src_height;
    } t_cfg;

    // per-channel sums of two pixels, each 9 bits
    function automatic logic [PAIR_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        logic [PAIR_W-1:0] s;
        s = '0;
        for (int c = 0; c < N_CHAN; c++) begin
            s[c*SUM_W +: SUM_W] = SUM_W'(a[c*CHAN_W +: CHAN_W])
                                + SUM_W'(b[c*CHAN_W +: CHAN_W]);
        end
        return s;
    endfunction

    // floor of the four-pixel sum over four, per channel
    function automatic logic [PIX_W-1:0] quad_avg(input logic [PAIR_W-1:0] a,
                                                  input logic [PAIR_W-1:0] b);
        logic [PIX_W-1:0]  r;
        logic [SUM_W:0]    t;
        r = '0;
        for (int c = 0; c < N_CHAN; c++) begin
            t = (SUM_W+1)'(a[c*SUM_W +: SUM_W]) + (SUM_W+1)'(b[c*SUM_W +: SUM_W]);
            r[c*CHAN_W +: CHAN_W] = t[SUM_W:2];
        end
        return r;
    endfunction

endpackage

### rtl/mbd_regs.sv
// configuration registers behind an apb-style slave port
// depends on mbd_pkg for the register map and t_cfg
module mbd_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbd_pkg::APB_AW-1:0]  paddr,
    input  logic [mbd_pkg::APB_DW-1:0]  pwdata,
    output logic [mbd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output mbd_pkg::t_cfg               o_cfg
);

    logic [mbd_pkg::SRC_W_W-1:0] r_src_width;
    logic [mbd_pkg::SRC_H_W-1:0] r_src_height;
    logic                        wr_en;
    logic                        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= mbd_pkg::SRC_W_W'(1);
            r_src_height <= mbd_pkg::SRC_H_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                mbd_pkg::REG_SRC_WIDTH:  r_src_width  <= pwdata[mbd_pkg::SRC_W_W-1:0];
                mbd_pkg::REG_SRC_HEIGHT: r_src_height <= pwdata[mbd_pkg::SRC_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mbd_pkg::REG_SRC_WIDTH:  prdata = mbd_pkg::APB_DW'(r_src_width);
            mbd_pkg::REG_SRC_HEIGHT: prdata = mbd_pkg::APB_DW'(r_src_height);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg.src_width  = r_src_width;
    assign o_cfg.src_height = r_src_height;

endmodule

### rtl/mbd_line_store.sv
// line store of horizontal pair sums, one write and one read port
// registered read data; depends on mbd_pkg only for the default width
module mbd_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = mbd_pkg::PAIR_W
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/mip_box_downsample_2x2_top.sv
// 2x2 box-filter mipmap downsampler, top level with datapath and counters
// depends on mbd_pkg, mbd_regs and mbd_line_store
//
// takes rgba8 source pixels in raster order, one beat per pixel, and gives
// one half-resolution pixel per 2x2 source block, each channel the floor of
// the four-pixel sum over four. an odd last column or row is replicated. the
// block accepts one pixel every clock while o_stall is low; a result beat
// passes through the pair register, loaded alongside the line store read,
// and then the output register. the only storage
// that sets the pace is the line store, one write and one read per cycle,
// which never collide since even rows write and odd rows read. o_last_pixel
// marks the final output of an image, after which the counters wrap and a new
// image begins. configure source_width and source_height over apb while idle
module mip_box_downsample_2x2_top #(
    parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbd_pkg::APB_AW-1:0]  paddr,
    input  logic [mbd_pkg::APB_DW-1:0]  pwdata,
    output logic [mbd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // source pixel beats
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [mbd_pkg::CHAN_W-1:0]  i_red_in,
    input  logic [mbd_pkg::CHAN_W-1:0]  i_green_in,
    input  logic [mbd_pkg::CHAN_W-1:0]  i_blue_in,
    input  logic [mbd_pkg::CHAN_W-1:0]  i_alpha_in,
    // downsampled pixel beats
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mbd_pkg::CHAN_W-1:0]  o_red_out,
    output logic [mbd_pkg::CHAN_W-1:0]  o_green_out,
    output logic [mbd_pkg::CHAN_W-1:0]  o_blue_out,
    output logic [mbd_pkg::CHAN_W-1:0]  o_alpha_out,
    output logic                        o_last_pixel
);

    // line store holds one pair sum per two columns
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = mbd_pkg::SRC_H_W;

    mbd_pkg::t_cfg cfg;

    mbd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // last column / row index from config, zero sizes count as one and
    // an over-wide image is clamped to the line store
    logic [31:0]      w_ext;
    logic [COL_W-1:0] last_col_idx;
    logic [ROW_W-1:0] last_row_idx;

    assign w_ext = 32'(cfg.src_width);

    always_comb begin
        if (w_ext == 32'd0) begin
            last_col_idx = '0;
        end else if (w_ext > 32'(MAX_WIDTH)) begin
            last_col_idx = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col_idx = COL_W'(w_ext - 32'd1);
        end
        if (cfg.src_height == '0) begin
            last_row_idx = '0;
        end else begin
            last_row_idx = cfg.src_height - ROW_W'(1);
        end
    end

    // raster position and held left pixel
    logic [COL_W-1:0]          r_col;
    logic [ROW_W-1:0]          r_row;
    logic [mbd_pkg::PIX_W-1:0] r_held;

    // stage 1: pair sum waiting for the line store read
    logic                       r_s1_valid;
    logic [mbd_pkg::PAIR_W-1:0] r_s1_pair;
    logic                       r_s1_use_line;
    logic                       r_s1_last;

    // output register
    logic                      r_out_valid;
    logic [mbd_pkg::PIX_W-1:0] r_out_pix;
    logic                      r_out_last;

    logic                       accept;
    logic                       s1_move;
    logic                       last_col;
    logic                       last_row;
    logic                       col_odd;
    logic                       row_odd;
    logic [mbd_pkg::PIX_W-1:0]  pix_in;
    logic [mbd_pkg::PIX_W-1:0]  left_pix;
    logic [mbd_pkg::PAIR_W-1:0] pair;
    logic                       pair_done;
    logic                       hold_en;
    logic                       line_wr;
    logic                       emit;
    logic                       line_rd;
    logic [LINE_AW-1:0]         line_addr;
    logic [mbd_pkg::PAIR_W-1:0] line_data;
    logic [mbd_pkg::PAIR_W-1:0] above;

    // stage 1 drains when the output register is free or being taken
    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // a column or row beyond the last one counts as the last one
    assign last_col = r_col >= last_col_idx;
    assign last_row = r_row >= last_row_idx;
    assign col_odd  = r_col[0];
    assign row_odd  = r_row[0];

    assign pix_in   = {i_alpha_in, i_blue_in, i_green_in, i_red_in};
    assign left_pix = col_odd ? r_held : pix_in;
    assign pair     = mbd_pkg::pair_sum(left_pix, pix_in);

    // even column not at the edge just holds; otherwise a pair is complete
    assign hold_en   = accept && !col_odd && !last_col;
    assign pair_done = accept && (col_odd || last_col);
    assign line_wr   = pair_done && !row_odd && !last_row;
    assign emit      = pair_done && (row_odd || last_row);
    assign line_rd   = emit && row_odd;
    assign line_addr = LINE_AW'(r_col >> 1);

    mbd_line_store #(
        .DEPTH (LINE_DEPTH),
        .AW    (LINE_AW),
        .DW    (mbd_pkg::PAIR_W)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr),
        .i_wr_addr (line_addr),
        .i_wr_data (pair),
        .i_rd_en   (line_rd),
        .i_rd_addr (line_addr),
        .o_rd_data (line_data)
    );

    // position counters, wrap at the end of the image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else begin
            if (hold_en) begin
                r_held <= pix_in;
            end
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept && emit) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1_pair     <= pair;
            r_s1_use_line <= row_odd;
            r_s1_last     <= last_col && last_row;
        end
    end

    // odd rows take the stored even-row pair, a lone last row uses itself
    assign above = r_s1_use_line ? line_data : r_s1_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_pix  <= mbd_pkg::quad_avg(above, r_s1_pair);
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red_out    = r_out_pix[0*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
    assign o_green_out  = r_out_pix[1*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
    assign o_blue_out   = r_out_pix[2*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
    assign o_alpha_out  = r_out_pix[3*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
    assign o_last_pixel = r_out_last;

endmodule
